FILE: design/vwh_pkg.sv
// Shared types and constants for the visual word histogram core.
`default_nettype none
package vwh_pkg;

	// Field and storage widths fixed by the interface.
	localparam int ELEM_W      = 16;
	localparam int COUNT_W     = 16;
	localparam int SUM_W       = 32;
	localparam int ROOT_W      = 17;
	localparam int DEF_MAX_DIM   = 128;
	localparam int DEF_MAX_WORDS = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [15:0]        NORM_ONE  = 16'd32768;

	// Input actions.
	localparam logic [2:0] ACT_LOAD   = 3'd0;
	localparam logic [2:0] ACT_DESC   = 3'd1;
	localparam logic [2:0] ACT_FINISH = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_BIN    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WORDS = 2'd0;
	localparam logic [1:0] CFG_LEN   = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_HRD,
		S_HUPD,
		S_ROOT,
		S_BRD,
		S_BDAT,
		S_DIV
	} vwh_state_t;

	// Command to the shared root and divide unit.
	typedef struct packed {
		logic start;
		logic is_root;
	} vwh_op_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         word;
		logic [COUNT_W-1:0] total;
		logic [COUNT_W-1:0] count;
		logic [15:0]        value;
		logic               ovf;
	} vwh_res_t;

endpackage
`default_nettype wire

FILE: design/vwh_rootdiv.sv
// Shared bit-serial unit: integer square root or unsigned division, one bit per cycle.
`default_nettype none
module vwh_rootdiv (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire vwh_pkg::vwh_op_t           op,
	input  wire logic [vwh_pkg::SUM_W-1:0]  a,
	input  wire logic [vwh_pkg::ROOT_W-1:0] b,
	output logic                            done,
	output logic [vwh_pkg::SUM_W-1:0]       q
);
	import vwh_pkg::*;

	logic              busy_q, done_q, root_q;
	logic [4:0]        cnt_q;
	logic [19:0]       rem_q;
	logic [SUM_W-1:0]  x_q, q_q;
	logic [ROOT_W-1:0] b_q;
	logic [19:0]       rsh, trial, rnew;
	logic              ge;

	// One compare-subtract step, shared by both operations.
	always_comb begin
		if (root_q) begin
			rsh   = {rem_q[17:0], x_q[SUM_W-1 -: 2]};
			trial = {1'b0, q_q[ROOT_W-1:0], 2'b01};
		end else begin
			rsh   = {rem_q[18:0], x_q[SUM_W-1]};
			trial = {3'b000, b_q};
		end
		ge   = rsh >= trial;
		rnew = ge ? rsh - trial : rsh;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (op.start) begin
				busy_q <= 1'b1;
				cnt_q  <= op.is_root ? 5'd15 : 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (op.start) begin
			root_q <= op.is_root;
			rem_q  <= '0;
			q_q    <= '0;
			x_q    <= a;
			b_q    <= b;
		end else if (busy_q) begin
			rem_q <= rnew;
			q_q   <= {q_q[SUM_W-2:0], ge};
			x_q   <= root_q ? {x_q[SUM_W-3:0], 2'b00} : {x_q[SUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign q    = q_q;

	// A result appears only at the end of a running operation.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a running operation");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !op.start) else $error("start while busy");
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && root_q) |-> (q_q[SUM_W-1:16] == '0))
		else $error("square root wider than 16 bits");

endmodule
`default_nettype wire

FILE: design/visual_word_histogram_core.sv
// Top level of the visual word histogram core: vocabulary, nearest-word scan and histogram.
// A final descriptor element starts a scan of every configured vocabulary word through the single
// multiply-accumulate over the vocabulary port. Finish and a bin read use the bit-serial root and
// divide unit (a bin read skips it with no norm); input waits while a result is held.
// Reset clears control state and per-bin valid bits at once; vocabulary and descriptor undefined.
`default_nettype none
module visual_word_histogram_core #(
	parameter int MAX_DIM   = vwh_pkg::DEF_MAX_DIM,
	parameter int MAX_WORDS = vwh_pkg::DEF_MAX_WORDS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [8:0]                  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  action,
	input  wire logic [7:0]                  word_index,
	input  wire logic [6:0]                  element_index,
	input  wire logic signed [vwh_pkg::ELEM_W-1:0] element_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       result_kind,
	output logic [7:0]                       assigned_word,
	output logic [vwh_pkg::COUNT_W-1:0]      descriptor_total,
	output logic [vwh_pkg::COUNT_W-1:0]      bin_count,
	output logic [15:0]                      bin_value,
	output logic                             count_overflow
);
	import vwh_pkg::*;

	localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int DA = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PW = $clog2(MAX_DIM + 1);
	localparam int VD = 1 << (WA + DA);
	localparam int DW = 2 * (ELEM_W + 1) + $clog2(MAX_DIM) + 1;

	vwh_state_t state_q, state_d;

	// Configuration and histogram status.
	logic [8:0]         wc_q;
	logic [7:0]         dl_q;
	logic [PW-1:0]      pos_q;
	logic [SUM_W-1:0]   sq_q;
	logic [COUNT_W-1:0] total_q;
	logic [ROOT_W-1:0]  root_q;
	logic               ovf_q;
	logic [MAX_WORDS-1:0] bin_vld_q;

	// Memories.
	logic signed [ELEM_W-1:0] vocab_mem [VD];
	logic signed [ELEM_W-1:0] desc_mem [MAX_DIM];
	logic [COUNT_W-1:0]       bin_mem [MAX_WORDS];
	logic signed [ELEM_W-1:0] vocab_rd_s1, desc_rd_s1;
	logic [COUNT_W-1:0]       bin_rd_q;

	// Scan counters and pipeline.
	logic          issue_q;
	logic [WA-1:0] cnt_w_q;
	logic [DA-1:0] cnt_e_q;
	logic          v_s1, v_s2, v_s3, le_s1, le_s2, le_s3, lw_s1, lw_s2, lw_s3;
	logic [WA-1:0] w_s1, w_s2, w_s3;
	logic signed [ELEM_W:0] diff_s2;
	logic [2*ELEM_W+1:0]    sq_s3;
	logic [DW-1:0]  acc_q, best_d_q, dsum;
	logic [WA-1:0]  best_q;

	// Bin read request.
	logic [WA-1:0]      rd_idx_q;
	logic [7:0]         rd_word_q;
	logic               rd_inr_q;
	logic [COUNT_W-1:0] rd_cnt_q;

	vwh_res_t res_q, out_q;
	logic     out_valid_q;

	// Shared unit.
	vwh_op_t          op;
	logic [SUM_W-1:0] unit_a, unit_q;
	logic             unit_done;

	logic acc_in, is_load, is_desc, is_fin, is_read, is_clear, scan_end;
	int   nw_eff, len_eff;
	logic [WA-1:0] wlast, bin_raddr;
	logic [DA-1:0] elast;
	logic [PW:0]   pos_next;
	logic [COUNT_W-1:0] hc, hc_new, tot_new;
	logic               hsat;
	logic [SUM_W:0]     sum33;
	logic [SUM_W-1:0]   sq_new;
	logic [COUNT_W-1:0] bc;

	assign cfg_ready = 1'b1;
	// A transaction is taken only when idle and no result is left waiting.
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign acc_in    = in_valid && in_ready;
	assign is_load   = acc_in && (action == ACT_LOAD);
	assign is_desc   = acc_in && (action == ACT_DESC);
	assign is_fin    = acc_in && (action == ACT_FINISH);
	assign is_read   = acc_in && (action == ACT_READ);
	assign is_clear  = acc_in && (action == ACT_CLEAR);

	// Effective register values clamped to the supported range.
	always_comb begin
		nw_eff  = (wc_q == '0) ? 1 : ((int'(wc_q) > MAX_WORDS) ? MAX_WORDS : int'(wc_q));
		len_eff = (dl_q == '0) ? 1 : ((int'(dl_q) > MAX_DIM) ? MAX_DIM : int'(dl_q));
		wlast   = WA'(nw_eff - 1);
		elast   = DA'(len_eff - 1);
		pos_next = {1'b0, pos_q} + 1'b1;
	end

	assign scan_end = v_s3 && le_s3 && lw_s3;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= 9'(MAX_WORDS);
			dl_q <= 8'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WORDS) begin
				wc_q <= cfg_data;
			end else if (cfg_index == CFG_LEN) begin
				dl_q <= cfg_data[7:0];
			end
		end
	end

	// Vocabulary memory: load port and scan read port.
	always_ff @(posedge clk) begin
		if (is_load && (int'(word_index) < MAX_WORDS) && (int'(element_index) < MAX_DIM)) begin
			vocab_mem[{WA'(32'(word_index)), DA'(32'(element_index))}] <= element_value;
		end
		vocab_rd_s1 <= vocab_mem[{cnt_w_q, cnt_e_q}];
	end

	// Descriptor buffer.
	always_ff @(posedge clk) begin
		if (is_desc) begin
			desc_mem[pos_q[DA-1:0]] <= element_value;
		end
		desc_rd_s1 <= desc_mem[cnt_e_q];
	end

	// Histogram update values.
	always_comb begin
		hc      = bin_vld_q[best_q] ? bin_rd_q : '0;
		hsat    = (hc == COUNT_MAX);
		sum33   = {1'b0, sq_q} + (SUM_W+1)'({hc, 1'b1});
		sq_new  = sum33[SUM_W] ? '1 : sum33[SUM_W-1:0];
		hc_new  = hsat ? hc : hc + 1'b1;
		tot_new = (total_q == COUNT_MAX) ? total_q : total_q + 1'b1;
		bc      = (rd_inr_q && bin_vld_q[rd_idx_q]) ? bin_rd_q : '0;
		bin_raddr = (state_q == S_BRD) ? rd_idx_q : best_q;
	end

	// Bin count memory.
	always_ff @(posedge clk) begin
		if (state_q == S_HUPD && !hsat) begin
			bin_mem[best_q] <= hc_new;
		end
		bin_rd_q <= bin_mem[bin_raddr];
	end

	// Scan issue counters and pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_w_q <= '0;
			cnt_e_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (is_desc && (int'(pos_next) >= len_eff)) begin
				issue_q <= 1'b1;
				cnt_w_q <= '0;
				cnt_e_q <= '0;
			end else if (issue_q) begin
				if (cnt_e_q == elast) begin
					cnt_e_q <= '0;
					cnt_w_q <= cnt_w_q + 1'b1;
					if (cnt_w_q == wlast) begin
						issue_q <= 1'b0;
					end
				end else begin
					cnt_e_q <= cnt_e_q + 1'b1;
				end
			end
		end
	end

	// Difference, square and accumulate stages.
	always_ff @(posedge clk) begin
		le_s1   <= (cnt_e_q == elast);
		lw_s1   <= (cnt_w_q == wlast);
		w_s1    <= cnt_w_q;
		le_s2   <= le_s1;
		lw_s2   <= lw_s1;
		w_s2    <= w_s1;
		diff_s2 <= (ELEM_W+1)'(desc_rd_s1) - (ELEM_W+1)'(vocab_rd_s1);
		le_s3   <= le_s2;
		lw_s3   <= lw_s2;
		w_s3    <= w_s2;
		sq_s3   <= unsigned'((2*ELEM_W+2)'(diff_s2) * (2*ELEM_W+2)'(diff_s2));
	end

	assign dsum = acc_q + DW'(sq_s3);

	// Running distance and best word.
	always_ff @(posedge clk) begin
		if (is_desc) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (le_s3) begin
				acc_q <= '0;
				if (w_s3 == '0 || dsum < best_d_q) begin
					best_d_q <= dsum;
					best_q   <= w_s3;
				end
			end else begin
				acc_q <= dsum;
			end
		end
	end

	// Shared unit command.
	always_comb begin
		op.start   = is_fin || (state_q == S_BDAT && sq_q != '0 && root_q != '0);
		op.is_root = is_fin;
		unit_a     = is_fin ? sq_q : (SUM_W'(bc) << 15);
	end

	vwh_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (unit_a),
		.b      (root_q),
		.done   (unit_done),
		.q      (unit_q)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (is_desc && (int'(pos_next) >= len_eff)) begin
					state_d = S_SCAN;
				end else if (is_fin) begin
					state_d = S_ROOT;
				end else if (is_read) begin
					state_d = S_BRD;
				end
			end
			S_SCAN: if (scan_end) state_d = S_HRD;
			S_HRD:  state_d = S_HUPD;
			S_BRD:  state_d = S_BDAT;
			S_BDAT: state_d = (sq_q != '0 && root_q != '0) ? S_DIV : S_IDLE;
			S_ROOT: if (unit_done) state_d = S_IDLE;
			S_DIV:  if (unit_done) state_d = S_IDLE;
			S_HUPD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Histogram status, element position and result staging.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sq_q      <= '0;
			total_q   <= '0;
			root_q    <= '0;
			ovf_q     <= 1'b0;
			bin_vld_q <= '0;
		end else begin
			if (is_desc) begin
				pos_q <= (int'(pos_next) >= len_eff) ? '0 : pos_next[PW-1:0];
			end
			if (is_clear) begin
				sq_q      <= '0;
				total_q   <= '0;
				root_q    <= '0;
				ovf_q     <= 1'b0;
				bin_vld_q <= '0;
			end
			if (state_q == S_HUPD) begin
				total_q <= tot_new;
				if (hsat) begin
					ovf_q <= 1'b1;
				end else begin
					sq_q <= sq_new;
					bin_vld_q[best_q] <= 1'b1;
				end
			end
			if (state_q == S_ROOT && unit_done) begin
				root_q <= unit_q[ROOT_W-1:0];
			end
		end
	end

	// Pending result fields and read request.
	always_ff @(posedge clk) begin
		if (is_read) begin
			rd_word_q <= word_index;
			rd_idx_q  <= WA'(32'(word_index));
			rd_inr_q  <= int'(word_index) < MAX_WORDS;
		end
		if (state_q == S_BDAT) begin
			rd_cnt_q <= bc;
		end
	end

	// Output register: loaded when a result completes, freed when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_HUPD || (state_q == S_BDAT && (sq_q == '0 || root_q == '0))
			    || ((state_q == S_ROOT || state_q == S_DIV) && unit_done)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res_q       = '0;
		res_q.total = total_q;
		res_q.ovf   = ovf_q;
		case (state_q)
			S_HUPD: begin
				res_q.kind  = KIND_WORD;
				res_q.word  = 8'(32'(best_q));
				res_q.total = tot_new;
				res_q.count = hc_new;
				res_q.ovf   = ovf_q | hsat;
			end
			S_ROOT: res_q.kind = KIND_FINISH;
			S_BDAT: begin
				res_q.kind  = KIND_BIN;
				res_q.word  = rd_word_q;
				res_q.count = bc;
			end
			S_DIV: begin
				res_q.kind  = KIND_BIN;
				res_q.word  = rd_word_q;
				res_q.count = rd_cnt_q;
				res_q.value = (unit_q > SUM_W'(NORM_ONE)) ? NORM_ONE : unit_q[15:0];
			end
			default: res_q.kind = KIND_WORD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HUPD || state_q == S_BDAT || unit_done) begin
			out_q <= res_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = out_q.kind;
	assign assigned_word    = out_q.word;
	assign descriptor_total = out_q.total;
	assign bin_count        = out_q.count;
	assign bin_value        = out_q.value;
	assign count_overflow   = out_q.ovf;

	// A scan always starts at the head of a new descriptor.
	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (pos_q == '0)) else $error("descriptor position not reset");
	// The overflow flag drops only on a clear transaction.
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ovf_q) |-> $past(is_clear)) else $error("overflow flag lost");
	// Normalized values never exceed one.
	a_norm_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_BIN) |-> (out_q.value <= NORM_ONE))
		else $error("normalized value above one");
	// A new result is never staged over one still waiting.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result dropped");

endmodule
`default_nettype wire
